[rtl/scoped_symbol_table_top_defines.svh]
// Assertion macros for the scoped symbol table.
// Used by the top level only; no other dependencies.
`ifndef SCOPED_SYMBOL_TABLE_TOP_DEFINES_SVH
`define SCOPED_SYMBOL_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scoped symbol table check failed");

// Next-cycle implication, checked outside reset
`define SST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scoped symbol table check failed");

`endif

[rtl/scst_pkg.sv]
// Shared types and constants of the scoped symbol table.
// No dependencies.
package scst_pkg;

    localparam int LEVEL_W = 8;
    localparam int SLOT_W  = 8;

    typedef enum logic [2:0] {
        OP_CHAR    = 3'd0,
        OP_DECLARE = 3'd1,
        OP_LOOKUP  = 3'd2,
        OP_PUSH    = 3'd3,
        OP_POP     = 3'd4,
        OP_CLEAR   = 3'd5
    } t_op;

    typedef struct packed {
        t_op  op;
        logic too_long;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

endpackage

[rtl/scst_front.sv]
// Front end: collects name bytes and forwards commands with a name snapshot.
// Depends on scst_pkg.
module scst_front #(
    parameter int NAME_BUFFER = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_mode,
    input  logic [7:0]               i_name_char,
    input  logic                     i_q_full,
    output logic                     o_q_push,
    output scst_pkg::t_cmd           o_q_cmd,
    output logic [NAME_BUFFER*8-1:0] o_q_name
);
    import scst_pkg::*;

    localparam int LENW = $clog2(NAME_BUFFER);

    logic [NAME_BUFFER-1:0][7:0] r_pend, n_pend;
    logic [LENW-1:0]             r_len, n_len;
    logic                        r_too_long, n_too_long;
    logic                        is_cmd;
    logic                        accept;

    // Classify the incoming mode
    always_comb begin
        unique case (i_mode)
            OP_DECLARE, OP_LOOKUP, OP_PUSH, OP_POP, OP_CLEAR: is_cmd = 1'b1;
            default:                                          is_cmd = 1'b0;
        endcase
    end

    assign o_in_ready     = is_cmd ? !i_q_full : 1'b1;
    assign accept         = i_in_valid && o_in_ready;
    assign o_q_push       = accept && is_cmd;
    assign o_q_cmd.op     = t_op'(i_mode);
    assign o_q_cmd.too_long = r_too_long;
    assign o_q_name       = r_pend;

    // Append bytes, empty the buffer after each command
    always_comb begin
        n_pend     = r_pend;
        n_len      = r_len;
        n_too_long = r_too_long;
        if (accept) begin
            if (is_cmd) begin
                n_pend     = '0;
                n_len      = '0;
                n_too_long = 1'b0;
            end else if (i_mode == OP_CHAR && i_name_char != 8'd0) begin
                if (r_len < LENW'(NAME_BUFFER - 1)) begin
                    n_pend[r_len] = i_name_char;
                    n_len         = r_len + 1'b1;
                end else begin
                    n_too_long = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= '0;
            r_len      <= '0;
            r_too_long <= 1'b0;
        end else begin
            r_pend     <= n_pend;
            r_len      <= n_len;
            r_too_long <= n_too_long;
        end
    end

endmodule

[rtl/scst_queue.sv]
// Two-entry command queue between front and back end.
// Depends on scst_pkg.
module scst_queue #(
    parameter int W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [W-1:0]       i_data,
    input  logic               i_pop,
    output logic [W-1:0]       o_data,
    output scst_pkg::t_q_stat  o_stat
);
    import scst_pkg::*;

    logic [1:0][W-1:0] r_mem;
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_data       = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/scst_back.sv]
// Back end: table memories, live bits, scope level, scans and result register.
// Depends on scst_pkg.
module scst_back #(
    parameter int SLOTS       = 256,
    parameter int NAME_BUFFER = 64,
    parameter int MAX_LEVEL   = 255
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  scst_pkg::t_cmd           i_q_cmd,
    input  logic [NAME_BUFFER*8-1:0] i_q_name,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [7:0]               o_slot,
    output logic                     o_found,
    output logic                     o_slots_exhausted
);
    import scst_pkg::*;

    localparam int IDXW  = $clog2(SLOTS);
    localparam int CNTW  = $clog2(SLOTS + 1);
    localparam int NAMEW = NAME_BUFFER * 8;

    // Memories
    logic [NAMEW-1:0]   name_mem [SLOTS];
    logic [LEVEL_W-1:0] lvl_mem  [SLOTS];
    logic [NAMEW-1:0]   r_name_rd;
    logic [LEVEL_W-1:0] r_lvl_rd;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [NAMEW-1:0]   r_key, n_key;
    logic [IDXW-1:0]    r_idx, n_idx;
    logic [CNTW-1:0]    r_left, n_left;
    logic               r_cmp_v, n_cmp_v;
    logic [IDXW-1:0]    r_cmp_idx, n_cmp_idx;
    logic [SLOTS-1:0]   r_live, n_live;
    logic [CNTW-1:0]    r_next_free, n_next_free;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               r_out_v, n_out_v;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic               r_out_found, n_out_found;
    logic               r_out_exh, n_out_exh;
    logic               we;
    logic               out_busy;

    assign o_out_valid       = r_out_v;
    assign o_slot            = r_out_slot;
    assign o_found           = r_out_found;
    assign o_slots_exhausted = r_out_exh;
    assign out_busy          = r_out_v && !i_out_ready;

    // Next state, table updates and results
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_idx       = r_idx;
        n_left      = r_left;
        n_cmp_v     = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_live      = r_live;
        n_next_free = r_next_free;
        n_level     = r_level;
        n_out_v     = out_busy;
        n_out_slot  = r_out_slot;
        n_out_found = r_out_found;
        n_out_exh   = r_out_exh;
        o_q_pop     = 1'b0;
        we          = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && !out_busy) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_cmd.op;
                    n_key   = i_q_name;
                    n_idx   = IDXW'(r_next_free - 1'b1);
                    n_left  = r_next_free;
                    unique case (i_q_cmd.op)
                        OP_DECLARE: begin
                            n_out_v = 1'b1;
                            if (r_next_free == CNTW'(SLOTS)) begin
                                n_out_slot  = '0;
                                n_out_found = 1'b0;
                                n_out_exh   = 1'b1;
                            end else begin
                                we          = 1'b1;
                                n_live[IDXW'(r_next_free)] = 1'b1;
                                n_next_free = r_next_free + 1'b1;
                                n_out_slot  = SLOT_W'(IDXW'(r_next_free));
                                n_out_found = 1'b1;
                                n_out_exh   = 1'b0;
                            end
                        end
                        OP_LOOKUP: begin
                            if (i_q_cmd.too_long || r_next_free == '0) begin
                                n_out_v     = 1'b1;
                                n_out_slot  = '0;
                                n_out_found = 1'b0;
                                n_out_exh   = 1'b0;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_PUSH: begin
                            if (r_level < LEVEL_W'(MAX_LEVEL)) n_level = r_level + 1'b1;
                        end
                        OP_POP: begin
                            if (r_next_free == '0) begin
                                if (r_level != '0) n_level = r_level - 1'b1;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_live      = '0;
                            n_next_free = '0;
                            n_level     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle, newest entry first
                if (r_left != '0) begin
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_idx;
                    n_idx     = r_idx - 1'b1;
                    n_left    = r_left - 1'b1;
                end
                // Check the entry read last cycle
                if (r_cmp_v) begin
                    if (r_op == OP_LOOKUP) begin
                        if (r_live[r_cmp_idx] && r_name_rd == r_key) begin
                            n_out_v     = 1'b1;
                            n_out_slot  = SLOT_W'(r_cmp_idx);
                            n_out_found = 1'b1;
                            n_out_exh   = 1'b0;
                            n_state     = ST_IDLE;
                            n_cmp_v     = 1'b0;
                        end else if (r_left == '0) begin
                            n_out_v     = 1'b1;
                            n_out_slot  = '0;
                            n_out_found = 1'b0;
                            n_out_exh   = 1'b0;
                            n_state     = ST_IDLE;
                        end
                    end else begin
                        if (r_live[r_cmp_idx] && r_lvl_rd == r_level) begin
                            n_live[r_cmp_idx] = 1'b0;
                        end
                        if (r_left == '0) begin
                            if (r_level != '0) n_level = r_level - 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Name and level memories
    always_ff @(posedge i_clk) begin
        if (we) begin
            name_mem[IDXW'(r_next_free)] <= i_q_name;
            lvl_mem[IDXW'(r_next_free)]  <= r_level;
        end
        r_name_rd <= name_mem[r_idx];
        r_lvl_rd  <= lvl_mem[r_idx];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_cmp_idx  <= n_cmp_idx;
        r_out_slot <= n_out_slot;
        r_out_found <= n_out_found;
        r_out_exh  <= n_out_exh;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_v     <= 1'b0;
            r_live      <= '0;
            r_next_free <= '0;
            r_level     <= '0;
            r_out_v     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_v     <= n_cmp_v;
            r_live      <= n_live;
            r_next_free <= n_next_free;
            r_level     <= n_level;
            r_out_v     <= n_out_v;
        end
    end

endmodule

[rtl/scoped_symbol_table_top.sv]
// Scoped symbol table top level: front end, command queue, back end.
// Depends on scst_pkg, scst_front, scst_queue, scst_back and the defines header.
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid/o_in_ready  | i_mode, i_name_char
//  out     | output    | o_out_valid/i_out_ready| o_slot, o_found, o_slots_exhausted
//
// The front end accepts a name byte even while the back end is busy.
// Declare, push, pop on an empty table, clear, and a lookup of a too-long name
// or on an empty table finish in the back end without a scan.
// Other lookups and pops scan the stored entries with one name-memory read
// per cycle; a lookup stops at the newest match.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A stalled result holds the back end; the front end keeps taking bytes.
`include "scoped_symbol_table_top_defines.svh"

module scoped_symbol_table_top #(
    parameter int SLOTS       = 256,
    parameter int NAME_BUFFER = 64,
    parameter int MAX_LEVEL   = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_name_char,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_slot,
    output logic       o_found,
    output logic       o_slots_exhausted
);
    import scst_pkg::*;

    localparam int NAMEW = NAME_BUFFER * 8;
    localparam int QW    = $bits(t_cmd) + NAMEW;

    t_q_stat          q_stat;
    logic             q_push, q_pop;
    t_cmd             f_cmd, b_cmd;
    logic [NAMEW-1:0] f_name, b_name;

    scst_front #(.NAME_BUFFER(NAME_BUFFER)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_name_char (i_name_char),
        .i_q_full    (q_stat.full),
        .o_q_push    (q_push),
        .o_q_cmd     (f_cmd),
        .o_q_name    (f_name)
    );

    scst_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_cmd, f_name}),
        .i_pop   (q_pop),
        .o_data  ({b_cmd, b_name}),
        .o_stat  (q_stat)
    );

    scst_back #(
        .SLOTS       (SLOTS),
        .NAME_BUFFER (NAME_BUFFER),
        .MAX_LEVEL   (MAX_LEVEL)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_stat.valid),
        .i_q_cmd           (b_cmd),
        .i_q_name          (b_name),
        .o_q_pop           (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_slot            (o_slot),
        .o_found           (o_found),
        .o_slots_exhausted (o_slots_exhausted)
    );

    // Checks
    `SST_ASSERT_NOW(a_found_not_exh, i_clk, i_rst_n, o_out_valid && o_found, !o_slots_exhausted)
    `SST_ASSERT_NOW(a_exh_slot_zero, i_clk, i_rst_n, o_out_valid && o_slots_exhausted, o_slot == 8'd0)
    `SST_ASSERT_NOW(a_pop_has_entry, i_clk, i_rst_n, q_pop, q_stat.valid)
    `SST_ASSERT_NEXT(a_full_stays_valid, i_clk, i_rst_n, q_stat.full && !q_pop, q_stat.full)

endmodule

[tb/scoped_symbol_table_top_tb.sv]
// Self-checking testbench for the scoped symbol table top level.
// Depends on scst_pkg and scoped_symbol_table_top; holds its own table predictor.
`timescale 1ns / 1ps

import scst_pkg::*;

class symtab_scoreboard;
    // predicted table contents
    logic [503:0] stored_name [256];
    bit           slot_live [256];
    logic [7:0]   slot_level [256];
    int unsigned  used_slots;
    int unsigned  cur_level;
    logic [503:0] pend_name;
    int unsigned  pend_len;
    bit           pend_long;
    // expected results, oldest first
    logic [9:0]   expected_q [$];
    int unsigned  n_errors;

    function void wipe();
        for (int k = 0; k < 256; k++) slot_live[k] = 0;
        used_slots = 0;
        cur_level  = 0;
        pend_name  = '0;
        pend_len   = 0;
        pend_long  = 0;
    endfunction

    function void note_input(logic [2:0] mode, logic [7:0] ch);
        logic [9:0] res;
        bit         hit;
        if (mode == OP_CHAR) begin
            if (ch != 8'd0) begin
                if (pend_len < 63) begin
                    pend_name[pend_len*8 +: 8] = ch;
                    pend_len++;
                end else begin
                    pend_long = 1;
                end
            end
            return;
        end
        if (mode > OP_CLEAR) return;
        case (mode)
            OP_DECLARE: begin
                if (used_slots >= 256) begin
                    res = {8'd0, 1'b0, 1'b1};
                end else begin
                    stored_name[used_slots] = pend_name;
                    slot_live[used_slots]   = 1;
                    slot_level[used_slots]  = cur_level[7:0];
                    res = {used_slots[7:0], 1'b1, 1'b0};
                    used_slots++;
                end
                expected_q.push_back(res);
            end
            OP_LOOKUP: begin
                res = '0;
                hit = 0;
                if (!pend_long) begin
                    for (int k = int'(used_slots) - 1; k >= 0 && !hit; k--) begin
                        if (slot_live[k] && stored_name[k] == pend_name) begin
                            res = {k[7:0], 1'b1, 1'b0};
                            hit = 1;
                        end
                    end
                end
                expected_q.push_back(res);
            end
            OP_PUSH: if (cur_level < 255) cur_level++;
            OP_POP: begin
                for (int k = 0; k < int'(used_slots); k++)
                    if (slot_live[k] && slot_level[k] == cur_level[7:0]) slot_live[k] = 0;
                if (cur_level > 0) cur_level--;
            end
            OP_CLEAR: wipe();
            default: ;
        endcase
        pend_name = '0;
        pend_len  = 0;
        pend_long = 0;
    endfunction

    function void check_result(logic [7:0] slot, logic found, logic exhausted);
        logic [9:0] exp_res;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result slot=%0d found=%0b exhausted=%0b",
                     $time, slot, found, exhausted);
            n_errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (exp_res[9:2] !== slot) begin
            $display("%0t: slot mismatch expected %0d actual %0d", $time, exp_res[9:2], slot);
            n_errors++;
        end
        if (exp_res[1] !== found) begin
            $display("%0t: found mismatch expected %0b actual %0b", $time, exp_res[1], found);
            n_errors++;
        end
        if (exp_res[0] !== exhausted) begin
            $display("%0t: exhausted mismatch expected %0b actual %0b",
                     $time, exp_res[0], exhausted);
            n_errors++;
        end
    endfunction
endclass

module scoped_symbol_table_top_tb;
    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_in_valid = 0;
    logic       o_in_ready;
    logic [2:0] i_mode = 3'd0;
    logic [7:0] i_name_char = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready = 0;
    logic [7:0] o_slot;
    logic       o_found;
    logic       o_slots_exhausted;

    symtab_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          stim_done;

    scoped_symbol_table_top uut (.*);

    always #4 i_clk = ~i_clk;

    // check every result transaction at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_slot, o_found, o_slots_exhausted);
    end

    // randomize receiver readiness at the falling edge
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // send one transaction, with optional idle gap before it; valid drops
    // only when the sender idles, so back-to-back items keep it high
    task automatic send_item(input logic [2:0] mode, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_mode      <= mode;
        i_name_char <= ch;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(mode, ch);
        @(negedge i_clk);
    endtask

    task automatic send_name(input int unsigned len, input int unsigned alpha);
        for (int k = 0; k < len; k++)
            send_item(OP_CHAR, 8'($urandom_range(alpha) + 1));
    endtask

    // hold until all results are back, then let the back end settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_name($urandom_range(3), 2);
                send_item(OP_DECLARE, 8'd0);
            end else if (pick < 70) begin
                send_name($urandom_range(3), 2);
                send_item(OP_LOOKUP, 8'd0);
            end else if (pick < 80) send_item(OP_PUSH, 8'd0);
            else if (pick < 88) send_item(OP_POP, 8'd0);
            else if (pick < 89) send_item(OP_CLEAR, 8'd0);
            else if (pick < 92) send_item(3'($urandom_range(6, 7)), 8'($urandom));
            else if (pick < 95) send_item(OP_CHAR, 8'd0);
            else send_item(OP_CHAR, 8'($urandom_range(1, 255)));
        end
    endtask

    initial begin
        sb = new();
        sb.wipe();
        sb.n_errors = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stim_done = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of bytes, every mode, long names
        send_item(OP_CHAR, 8'd255);
        send_item(OP_CHAR, 8'd1);
        send_item(OP_CHAR, 8'd0);
        send_item(OP_DECLARE, 8'd0);
        send_item(OP_LOOKUP, 8'd0);
        send_item(OP_CHAR, 8'd255);
        send_item(OP_CHAR, 8'd1);
        send_item(OP_LOOKUP, 8'd0);
        send_item(OP_PUSH, 8'd0);
        send_item(OP_DECLARE, 8'd0);
        send_item(OP_LOOKUP, 8'd0);
        send_item(OP_POP, 8'd0);
        send_item(OP_LOOKUP, 8'd0);
        send_item(OP_POP, 8'd0);
        send_item(3'd6, 8'hAA);
        send_item(3'd7, 8'h55);
        send_name(63, 254);
        send_item(OP_DECLARE, 8'd0);
        send_name(64, 254);
        send_item(OP_LOOKUP, 8'd0);
        send_item(OP_CLEAR, 8'd0);
        drain();

        // push to the ceiling, then pop past the floor
        for (int k = 0; k < 257; k++) send_item(OP_PUSH, 8'd0);
        send_item(OP_DECLARE, 8'd0);
        for (int k = 0; k < 258; k++) send_item(OP_POP, 8'd0);
        send_item(OP_LOOKUP, 8'd0);
        // fill every slot and go past it
        for (int k = 0; k < 258; k++) begin
            if (k % 8 == 0) send_item(OP_CHAR, 8'($urandom_range(1, 4)));
            send_item(OP_DECLARE, 8'd0);
        end
        send_item(OP_CHAR, 8'd2);
        send_item(OP_LOOKUP, 8'd0);
        send_item(OP_CLEAR, 8'd0);
        drain();

        // random phases with varied idling
        random_phase(55);
        send_idle_pct = 47;
        random_phase(55);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 47;
        random_phase(55);
        send_idle_pct = 35;
        recv_stall_pct = 35;
        random_phase(55);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(30);

        drain();
        if (sb.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #30ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

[scoped_symbol_table_top.f]
+incdir+rtl
rtl/scst_pkg.sv
rtl/scst_front.sv
rtl/scst_queue.sv
rtl/scst_back.sv
rtl/scoped_symbol_table_top.sv
tb/scoped_symbol_table_top_tb.sv
